### hw/rtl/bfa_pkg.sv
// shared constants, request codes and helpers for the bitmap frame allocator
package bfa_pkg;

  localparam int BITMAP_WORDS_DEF = 2048;
  localparam int FRAME_SHIFT_DEF  = 12;

  localparam int ADDR_W  = 28;
  localparam int COUNT_W = 17;
  localparam int WORD_W  = 32;
  localparam int BIT_W   = 5;
  localparam int MODE_W  = 2;

  localparam logic [WORD_W-1:0]  FULL_WORD = 32'hFFFF_FFFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h1_FFFF;

  localparam logic [MODE_W-1:0] MODE_ALLOC     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE      = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MARK_USED = 2'd2;
  localparam logic [MODE_W-1:0] MODE_MARK_FREE = 2'd3;

  // position of the lowest set bit, five halving steps
  function automatic logic [BIT_W-1:0] low_set(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] x;
    logic [BIT_W-1:0]  p;
    x = v;
    p = '0;
    if (x[15:0] == 16'd0) begin
      p[4] = 1'b1;
      x = x >> 16;
    end
    if (x[7:0] == 8'd0) begin
      p[3] = 1'b1;
      x = x >> 8;
    end
    if (x[3:0] == 4'd0) begin
      p[2] = 1'b1;
      x = x >> 4;
    end
    if (x[1:0] == 2'd0) begin
      p[1] = 1'b1;
      x = x >> 2;
    end
    if (x[0] == 1'b0) begin
      p[0] = 1'b1;
    end
    return p;
  endfunction

endpackage

### hw/rtl/bfa_bitmap_ram.sv
// single-port bitmap memory, read data registered
module bfa_bitmap_ram #(
  parameter int WORDS = bfa_pkg::BITMAP_WORDS_DEF,
  parameter int AW    = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic                      we,
  input  logic [AW-1:0]             addr,
  input  logic [bfa_pkg::WORD_W-1:0] wdata,
  output logic [bfa_pkg::WORD_W-1:0] rdata
);
  import bfa_pkg::*;

  logic [WORD_W-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

### hw/rtl/bfa_ctrl.sv
// request sequencer: clearing pass, first-fit scan, read-modify-write, result register
module bfa_ctrl #(
  parameter int WORDS       = bfa_pkg::BITMAP_WORDS_DEF,
  parameter int FRAME_SHIFT = bfa_pkg::FRAME_SHIFT_DEF,
  parameter int AW          = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bfa_pkg::MODE_W-1:0]  in_mode,
  input  logic [bfa_pkg::ADDR_W-1:0]  in_address,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_ok,
  output logic [bfa_pkg::ADDR_W-1:0]  out_frame_address,
  output logic [bfa_pkg::COUNT_W-1:0] out_used_count,
  output logic                        mem_en,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_addr,
  output logic [bfa_pkg::WORD_W-1:0]  mem_wdata,
  input  logic [bfa_pkg::WORD_W-1:0]  mem_rdata
);
  import bfa_pkg::*;

  localparam int FBITS = AW + BIT_W;
  localparam int WIDE  = FBITS + FRAME_SHIFT + ADDR_W;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_MOD    = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

  logic [2:0]         state;
  logic [AW-1:0]      clr_idx;
  logic [AW-1:0]      scan_idx;
  logic [AW-1:0]      hint;
  logic [COUNT_W-1:0] count;
  logic [MODE_W-1:0]  req_mode;
  logic [AW-1:0]      req_word;
  logic [BIT_W-1:0]   req_bit;
  logic               res_ok;
  logic [ADDR_W-1:0]  res_faddr;

  logic [ADDR_W-1:0]  frame;
  logic               in_range;
  logic [AW-1:0]      in_word;
  logic               accept;
  logic               word_full;
  logic [BIT_W-1:0]   free_bit;
  logic [WORD_W-1:0]  alloc_mask;
  logic [WORD_W-1:0]  req_mask;
  logic [WIDE-1:0]    alloc_wide;

  assign frame      = in_address >> FRAME_SHIFT;
  assign in_range   = 32'(frame) < 32'(WORDS * WORD_W);
  assign in_word    = AW'(frame >> BIT_W);
  assign in_ready   = (state == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign word_full  = (mem_rdata == FULL_WORD);
  assign free_bit   = low_set(~mem_rdata);
  assign alloc_mask = WORD_W'(1) << free_bit;
  assign req_mask   = WORD_W'(1) << req_bit;
  assign alloc_wide = WIDE'({scan_idx, free_bit}) << FRAME_SHIFT;

  // memory port: one access per cycle, writes never overlap the next read
  always_comb begin
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = scan_idx;
    mem_wdata = mem_rdata;
    case (state)
      ST_CLEAR: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = clr_idx;
        mem_wdata = FULL_WORD;
      end
      ST_IDLE: begin
        if (accept && (in_mode == MODE_ALLOC || in_range)) begin
          mem_en   = 1'b1;
          mem_addr = (in_mode == MODE_ALLOC) ? hint : in_word;
        end
      end
      ST_SCAN: begin
        if (!word_full) begin
          mem_en    = 1'b1;
          mem_we    = 1'b1;
          mem_addr  = scan_idx;
          mem_wdata = mem_rdata | alloc_mask;
        end else if (scan_idx != LAST_WORD) begin
          mem_en   = 1'b1;
          mem_addr = scan_idx + AW'(1);
        end
      end
      ST_MOD: begin
        mem_en   = 1'b1;
        mem_we   = 1'b1;
        mem_addr = req_word;
        if (req_mode == MODE_MARK_USED) begin
          mem_wdata = mem_rdata | req_mask;
        end else begin
          mem_wdata = mem_rdata & ~req_mask;
        end
      end
      default: begin
        mem_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      hint      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + AW'(1);
          if (clr_idx == LAST_WORD) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            req_mode  <= in_mode;
            req_word  <= in_word;
            req_bit   <= frame[BIT_W-1:0];
            scan_idx  <= hint;
            res_faddr <= '0;
            res_ok    <= (in_mode == MODE_ALLOC) || in_range;
            if (in_mode == MODE_ALLOC) begin
              state <= ST_SCAN;
            end else if (in_range) begin
              state <= ST_MOD;
            end else begin
              state <= ST_FINISH;
            end
          end
        end
        ST_SCAN: begin
          if (!word_full) begin
            res_faddr <= alloc_wide[ADDR_W-1:0];
            hint      <= scan_idx;
            if (count != COUNT_MAX) begin
              count <= count + COUNT_W'(1);
            end
            state <= ST_FINISH;
          end else if (scan_idx == LAST_WORD) begin
            res_ok <= 1'b0;
            state  <= ST_FINISH;
          end else begin
            scan_idx <= scan_idx + AW'(1);
          end
        end
        ST_MOD: begin
          if (req_mode != MODE_MARK_USED && req_word < hint) begin
            hint <= req_word;
          end
          if (req_mode == MODE_FREE && count != '0) begin
            count <= count - COUNT_W'(1);
          end
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid         <= 1'b1;
            out_ok            <= res_ok;
            out_frame_address <= res_faddr;
            out_used_count    <= count;
            state             <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_no_accept_in_clear : assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !in_ready)
    else $error("request taken during clearing pass");

  a_write_then_finish : assert property (@(posedge clk) disable iff (rst)
    (mem_we && state != ST_CLEAR) |=> (state == ST_FINISH))
    else $error("bitmap write not followed by result stage");

  a_count_step : assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (count == $past(count)) || (count == $past(count) + COUNT_W'(1))
             || (count == $past(count) - COUNT_W'(1)))
    else $error("used count moved by more than one");

  a_fail_zero_addr : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ok) |-> (out_frame_address == '0))
    else $error("failed request carries a frame address");
`endif

endmodule

### hw/rtl/bitmap_frame_allocator.sv
// top level of the first-fit bitmap page frame allocator
// One bit per physical page frame (set = used), 32 frames per word, kept in a
// single-port memory of BITMAP_WORDS words with a registered read. After
// reset a clearing pass writes every word to all ones, during which s_tready
// stays low. Requests are served one at a time: after accept a free or mark
// request does one read-modify-write, then the result register is loaded (an
// address beyond the bitmap skips the read-modify-write). Allocate scans one
// bitmap word per cycle from a hint that marks the lowest word that may hold a
// free frame; the hint moves down on free and mark-free and up to the word that
// served the last allocation, so when frames are handed out and returned in a
// stack-like way the scan usually hits on its first word. The memory port is
// the limit: each word scanned costs one read. A result waits in the output
// register while the next request is accepted.
module bitmap_frame_allocator #(
  parameter int BITMAP_WORDS = bfa_pkg::BITMAP_WORDS_DEF,
  parameter int FRAME_SHIFT  = bfa_pkg::FRAME_SHIFT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [27:0] address, [31:28] zero
  input  logic [1:0]  s_tuser,   // [1:0] mode
  // result channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [27:0] frame_address, [44:28] used_count, [47:45] zero
  output logic        m_tuser    // [0] ok
);
  import bfa_pkg::*;

  localparam int AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;

  logic               mem_en;
  logic               mem_we;
  logic [AW-1:0]      mem_addr;
  logic [WORD_W-1:0]  mem_wdata;
  logic [WORD_W-1:0]  mem_rdata;
  logic [ADDR_W-1:0]  out_frame_address;
  logic [COUNT_W-1:0] out_used_count;

  // sequencer owns the memory port and the result register
  bfa_ctrl #(
    .WORDS       (BITMAP_WORDS),
    .FRAME_SHIFT (FRAME_SHIFT),
    .AW          (AW)
  ) u_ctrl (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (s_tvalid),
    .in_ready          (s_tready),
    .in_mode           (s_tuser),
    .in_address        (s_tdata[ADDR_W-1:0]),
    .out_valid         (m_tvalid),
    .out_ready         (m_tready),
    .out_ok            (m_tuser),
    .out_frame_address (out_frame_address),
    .out_used_count    (out_used_count),
    .mem_en            (mem_en),
    .mem_we            (mem_we),
    .mem_addr          (mem_addr),
    .mem_wdata         (mem_wdata),
    .mem_rdata         (mem_rdata)
  );

  // used/free bitmap
  bfa_bitmap_ram #(
    .WORDS (BITMAP_WORDS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // result payload packed lowest field first
  assign m_tdata = {3'b000, out_used_count, out_frame_address};

endmodule

### tb/sv/tb_top.sv
// self-checking stream testbench for the first-fit bitmap page frame allocator
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bfa_pkg::*;

  localparam int MAP_WORDS   = BITMAP_WORDS_DEF;
  localparam int FRAME_SHIFT = FRAME_SHIFT_DEF;
  localparam int MAP_FRAMES  = MAP_WORDS * WORD_W;
  localparam int RANDOM_REQS = 1130;
  // idle cycles allowed: clearing pass plus a full failed scan, many times over
  localparam int IDLE_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 64;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] addr;
  } frame_req_t;

  typedef struct packed {
    logic               ok;
    logic [ADDR_W-1:0]  frame_address;
    logic [COUNT_W-1:0] used_count;
  } grant_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;
  logic        m_tuser;

  bitmap_frame_allocator i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [27:0] address, [31:28] zero
    .s_tuser  (s_tuser),   // [1:0] mode
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // [27:0] frame_address, [44:28] used_count, [47:45] zero
    .m_tuser  (m_tuser)    // [0] ok
  );

  always #1 clk = ~clk;

  // shadow of the allocator state
  logic [WORD_W-1:0]  frame_map [MAP_WORDS];
  logic [COUNT_W-1:0] counted_frames;

  frame_req_t pending_reqs[$];
  grant_t     grant_q[$];
  logic       req_taken;
  int         mismatch_count;
  int         alloc_hits, alloc_misses, counted_frees, mark_reqs, ignored_reqs;

  // first-fit allocation and bit updates, one request at a time
  function automatic grant_t serve_request(input logic [MODE_W-1:0] mode,
                                           input logic [ADDR_W-1:0] addr);
    grant_t g;
    int     frame;
    int     found;
    g.ok = 1'b1;
    g.frame_address = '0;
    frame = int'(addr >> FRAME_SHIFT);
    if (mode == MODE_ALLOC) begin
      found = -1;
      for (int w = 0; w < MAP_WORDS && found < 0; w++) begin
        if (frame_map[w] != FULL_WORD) begin
          for (int b = 0; b < WORD_W && found < 0; b++) begin
            if (!frame_map[w][b]) found = w * WORD_W + b;
          end
        end
      end
      if (found < 0) begin
        g.ok = 1'b0;
        alloc_misses++;
      end else begin
        frame_map[found / WORD_W][found % WORD_W] = 1'b1;
        if (counted_frames < COUNT_MAX) counted_frames++;
        g.frame_address = ADDR_W'(found << FRAME_SHIFT);
        alloc_hits++;
      end
    end else if (frame >= MAP_FRAMES) begin
      // frame beyond the bitmap: nothing changes
      g.ok = 1'b0;
      ignored_reqs++;
    end else if (mode == MODE_FREE) begin
      frame_map[frame / WORD_W][frame % WORD_W] = 1'b0;
      if (counted_frames != 0) counted_frames--;
      counted_frees++;
    end else if (mode == MODE_MARK_USED) begin
      frame_map[frame / WORD_W][frame % WORD_W] = 1'b1;
      mark_reqs++;
    end else begin
      frame_map[frame / WORD_W][frame % WORD_W] = 1'b0;
      mark_reqs++;
    end
    g.used_count = counted_frames;
    return g;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < 40)
      $display("mismatch %0s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  function automatic void add_req(input logic [MODE_W-1:0] mode, input logic [ADDR_W-1:0] addr);
    frame_req_t r;
    r.mode = mode;
    r.addr = addr;
    pending_reqs.push_back(r);
  endfunction

  // byte address of a frame with random offset bits below the frame number
  function automatic logic [ADDR_W-1:0] frame_addr(input int frame);
    return (ADDR_W'(frame) << FRAME_SHIFT) | ADDR_W'($urandom & ((1 << FRAME_SHIFT) - 1));
  endfunction

  // check results against the oldest prediction, then predict each accepted request
  always @(posedge clk) begin
    grant_t     want;
    frame_req_t req;
    req_taken <= s_tvalid && s_tready;
    if (m_tvalid && m_tready) begin
      if (grant_q.size() == 0) begin
        report_mismatch("unexpected result transaction", m_tdata[31:0], 32'd0);
      end else begin
        want = grant_q.pop_front();
        if (m_tuser != want.ok)
          report_mismatch("ok", 32'(m_tuser), 32'(want.ok));
        if (m_tdata[ADDR_W-1:0] != want.frame_address)
          report_mismatch("frame_address", 32'(m_tdata[ADDR_W-1:0]), 32'(want.frame_address));
        if (m_tdata[ADDR_W +: COUNT_W] != want.used_count)
          report_mismatch("used_count", 32'(m_tdata[ADDR_W +: COUNT_W]), 32'(want.used_count));
      end
    end
    if (s_tvalid && s_tready) begin
      req.mode = s_tuser;
      req.addr = s_tdata[ADDR_W-1:0];
      grant_q.push_back(serve_request(req.mode, req.addr));
    end
  end

  // watchdog: too long without any transaction on either side
  always @(posedge clk) begin
    int idle_cycles;
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  // request driver: bursts of random length, random gaps between them
  always @(negedge clk) begin
    frame_req_t req;
    int         burst_left;
    int         gap_left;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || req_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req = pending_reqs.pop_front();
        s_tdata  <= {4'd0, req.addr};
        s_tuser  <= req.mode;
        s_tvalid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result receiver: stretches of always ready, random stalls or a rotating pattern
  always @(negedge clk) begin
    int                ready_style;
    int                style_left;
    logic [WORD_W-1:0] stall_pattern;
    if (style_left == 0) begin
      ready_style   = $urandom_range(0, 2);
      style_left    = $urandom_range(20, 300);
      stall_pattern = $urandom | 32'd1;
    end else begin
      style_left--;
    end
    case (ready_style)
      0: begin
        m_tready <= 1'b1;
      end
      1: begin
        m_tready <= $urandom_range(0, 1);
      end
      default: begin
        m_tready <= stall_pattern[0];
        stall_pattern = {stall_pattern[0], stall_pattern[WORD_W-1:1]};
      end
    endcase
  end

  initial begin
    int free_pool[$];
    int kind;
    int n;
    int frame;
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    req_taken = 1'b0;
    mismatch_count = 0;
    for (int w = 0; w < MAP_WORDS; w++) frame_map[w] = FULL_WORD;
    counted_frames = '0;

    // directed part: every frame used after reset, count at zero
    add_req(MODE_ALLOC, 28'h0);              // no free frame
    add_req(MODE_FREE, 28'h0000000);         // free with count at zero
    add_req(MODE_FREE, 28'h0000FFF);         // free of a frame already free
    add_req(MODE_ALLOC, 28'hFFFFFFF);        // takes frame 0, address ignored
    add_req(MODE_ALLOC, 28'h0);              // full again
    add_req(MODE_MARK_FREE, 28'hFFFFFFF);    // top frame, all offset bits set
    add_req(MODE_MARK_FREE, 28'h0001FFF);
    add_req(MODE_MARK_FREE, 28'h0020ABC);    // first frame of the second word
    add_req(MODE_ALLOC, 28'h0);
    add_req(MODE_ALLOC, 28'h0);
    add_req(MODE_ALLOC, 28'h0);              // deep scan to the top frame
    add_req(MODE_FREE, 28'hFFFF000);
    add_req(MODE_FREE, 28'h0001000);
    add_req(MODE_FREE, 28'h0001800);         // already free
    add_req(MODE_MARK_USED, 28'h0001234);
    add_req(MODE_ALLOC, 28'h0);
    add_req(MODE_MARK_FREE, 28'h8000000);
    add_req(MODE_MARK_USED, 28'h8000000);
    add_req(MODE_FREE, 28'h5555555);
    add_req(MODE_MARK_FREE, 28'hAAAAAAA);
    add_req(MODE_ALLOC, 28'h0);
    add_req(MODE_ALLOC, 28'h0);
    add_req(MODE_MARK_USED, 28'h0000000);
    add_req(MODE_FREE, 28'h0000000);

    // random part: mostly set-up, allocate and free runs over the low frames
    while (pending_reqs.size() < RANDOM_REQS + 24) begin
      kind = $urandom_range(0, 9);
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
        if (kind <= 2) begin
          frame = $urandom_range(0, 1023);
          add_req(MODE_MARK_FREE, frame_addr(frame));
          free_pool.push_back(frame);
          if (free_pool.size() > 64) void'(free_pool.pop_front());
        end else if (kind <= 5) begin
          add_req(MODE_ALLOC, ADDR_W'($urandom));
        end else if (kind <= 7) begin
          frame = (free_pool.size() > 0) ? free_pool[$urandom_range(0, free_pool.size() - 1)]
                                         : $urandom_range(0, 1023);
          add_req(MODE_FREE, frame_addr(frame));
        end else if (kind == 8) begin
          add_req(MODE_MARK_USED, ADDR_W'($urandom));
        end else begin
          // noise over the whole address range and every mode
          add_req(MODE_W'($urandom_range(0, 3)), ADDR_W'($urandom));
        end
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || s_tvalid || grant_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d allocations, %0d failed allocations, %0d counted frees",
             alloc_hits, alloc_misses, counted_frees);
    $display("plus %0d uncounted marks and %0d out-of-range requests, %0d mismatches",
             mark_reqs, ignored_reqs, mismatch_count);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/bfa_pkg.sv
hw/rtl/bfa_bitmap_ram.sv
hw/rtl/bfa_ctrl.sv
hw/rtl/bitmap_frame_allocator.sv
tb/sv/tb_top.sv
